// ===== hdl/smvc_pkg.sv =====
// shared types and constants for the sample mean, variance and confidence core
`default_nettype none
package smvc_pkg;

	// z factors in Q.16
	localparam logic [17:0] Z_95_Q16 = 18'd128451;
	localparam logic [17:0] Z_99_Q16 = 18'd168821;

	localparam int OUT_DATA_W = 176;

	typedef enum logic [1:0] {
		DIV_MEAN,
		DIV_VAR,
		DIV_VAR_N
	} div_sel_t;

	typedef struct packed {
		logic     div_start;
		div_sel_t div_sel;
		logic     mean_ld;
		logic     pass_start;
		logic     pass_run;
		logic     var_ld;
		logic     var_n_ld;
		logic     sqrt_start;
		logic     half_ld;
		logic     out_ld;
	} dp_cmd_t;

	typedef struct packed {
		logic last_xfer;
		logic div_done;
		logic pass_done;
		logic sqrt_done;
		logic out_free;
	} dp_status_t;

endpackage
`default_nettype wire

// ===== hdl/smvc_div.sv =====
// restoring divider, one quotient bit per cycle
`default_nettype none
module smvc_div #(
	parameter int NUM_W = 75,
	parameter int DEN_W = 11
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             start,
	input  wire logic [NUM_W-1:0] num,
	input  wire logic [DEN_W-1:0] den,
	output logic      [NUM_W-1:0] quo,
	output logic                  done
);
	localparam int CNT_W = $clog2(NUM_W + 1);

	logic [DEN_W-1:0] rem_q;
	logic [NUM_W-1:0] quo_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic             done_q;
	logic [DEN_W:0]   trial;
	logic [DEN_W:0]   diff;
	logic             ge;

	assign trial = {rem_q, quo_q[NUM_W-1]};
	assign ge    = trial >= {1'b0, den};
	assign diff  = trial - {1'b0, den};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(NUM_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= num;
		end else if (busy_q) begin
			rem_q <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
			quo_q <= {quo_q[NUM_W-2:0], ge};
		end
	end

	assign quo  = quo_q;
	assign done = done_q;
endmodule
`default_nettype wire

// ===== hdl/smvc_sqrt.sv =====
// 64-bit integer square root, one root bit per cycle
`default_nettype none
module smvc_sqrt (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	input  wire logic [63:0] radicand,
	output logic      [31:0] root,
	output logic             done
);
	logic [63:0] rad_q;
	logic [34:0] rem_q;
	logic [31:0] root_q;
	logic [5:0]  cnt_q;
	logic        busy_q;
	logic        done_q;
	logic [34:0] trial_rem;
	logic [34:0] trial;
	logic        ge;

	assign trial_rem = {rem_q[32:0], rad_q[63:62]};
	assign trial     = {1'b0, root_q, 2'b01};
	assign ge        = trial_rem >= trial;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= 6'd32;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == 6'd1) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rad_q  <= radicand;
			rem_q  <= '0;
			root_q <= '0;
		end else if (busy_q) begin
			rad_q  <= {rad_q[61:0], 2'b00};
			rem_q  <= ge ? trial_rem - trial : trial_rem;
			root_q <= {root_q[30:0], ge};
		end
	end

	assign root = root_q;
	assign done = done_q;
endmodule
`default_nettype wire

// ===== hdl/smvc_datapath.sv =====
// sample store, running sum, deviation pass, shared divider, square root and output register
`default_nettype none
module smvc_datapath #(
	parameter int MAX_SAMPLES = 1024
) (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire smvc_pkg::dp_cmd_t                  cmd,
	output smvc_pkg::dp_status_t                    status,
	input  wire logic                               level,
	input  wire logic                               in_xfer,
	input  wire logic [31:0]                        in_sample,
	input  wire logic                               in_last,
	output logic                                    out_valid,
	input  wire logic                               out_ready,
	output logic      [smvc_pkg::OUT_DATA_W-1:0]    out_data
);
	import smvc_pkg::*;

	localparam int CW = $clog2(MAX_SAMPLES + 1);
	localparam int AW = $clog2(MAX_SAMPLES);
	localparam int SW = 32 + CW;
	localparam int NW = 64 + CW;

	logic [31:0]        mem [MAX_SAMPLES];
	logic [31:0]        rd_s1;
	logic               v_s1, v_s2, v_s3;
	logic [31:0]        absd_s2;
	logic [63:0]        sq_s3;

	logic [CW-1:0]      count_q;
	logic [SW-1:0]      sum_q;
	logic               drop_q;
	logic [CW-1:0]      idx_q;
	logic [NW-1:0]      acc_q;
	logic [31:0]        mean_q;
	logic [63:0]        var_q;
	logic [63:0]        var_n_q;
	logic [33:0]        half_q;

	logic               full;
	logic               neg;
	logic [SW-1:0]      mag;
	logic [SW:0]        adj;
	logic [NW-1:0]      div_num;
	logic [NW-1:0]      div_quo;
	logic               div_done;
	logic [31:0]        sqrt_root;
	logic               sqrt_done;
	logic [32:0]        diff;
	logic [17:0]        zf;
	logic [49:0]        prod;
	logic [35:0]        m36, lo36, hi36;
	logic [CW+10:0]     count_ext;
	logic               out_valid_q;
	logic [OUT_DATA_W-1:0] out_data_q;

	function automatic logic [31:0] sat32(input logic [35:0] v);
		logic [31:0] r;
		if (!v[35] && v[34:31] != 4'b0000)
			r = 32'h7fff_ffff;
		else if (v[35] && v[34:31] != 4'b1111)
			r = 32'h8000_0000;
		else
			r = v[31:0];
		return r;
	endfunction

	assign full = count_q == CW'(MAX_SAMPLES);

	// sample load and set bookkeeping
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			sum_q   <= '0;
			drop_q  <= 1'b0;
		end else if (cmd.out_ld) begin
			count_q <= '0;
			sum_q   <= '0;
			drop_q  <= 1'b0;
		end else if (in_xfer) begin
			if (full) begin
				drop_q <= 1'b1;
			end else begin
				count_q <= count_q + 1'b1;
				sum_q   <= sum_q + SW'($signed(in_sample));
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer && !full)
			mem[count_q[AW-1:0]] <= in_sample;
		rd_s1 <= mem[idx_q[AW-1:0]];
	end

	// floor division of a negative sum goes through the ceiling of its magnitude
	assign neg = sum_q[SW-1];
	assign mag = neg ? -sum_q : sum_q;
	assign adj = {1'b0, mag} + (neg ? {1'b0, SW'(count_q) - 1'b1} : '0);

	always_comb begin
		case (cmd.div_sel)
			DIV_MEAN:  div_num = NW'(adj);
			DIV_VAR:   div_num = acc_q;
			DIV_VAR_N: div_num = {{(NW-64){1'b0}}, var_q};
			default:   div_num = '0;
		endcase
	end

	smvc_div #(.NUM_W(NW), .DEN_W(CW)) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.div_start),
		.num    (div_num),
		.den    (count_q),
		.quo    (div_quo),
		.done   (div_done)
	);

	smvc_sqrt u_sqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.sqrt_start),
		.radicand (var_n_q),
		.root     (sqrt_root),
		.done     (sqrt_done)
	);

	// deviation pass: read, absolute deviation, square, accumulate
	assign diff = {rd_s1[31], rd_s1} - {mean_q[31], mean_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1  <= 1'b0;
			v_s2  <= 1'b0;
			v_s3  <= 1'b0;
			idx_q <= '0;
		end else begin
			v_s1 <= cmd.pass_run && idx_q != count_q;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			if (cmd.pass_start)
				idx_q <= '0;
			else if (cmd.pass_run && idx_q != count_q)
				idx_q <= idx_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		absd_s2 <= diff[32] ? 32'(-diff) : diff[31:0];
		sq_s3   <= absd_s2 * absd_s2;
		if (cmd.pass_start)
			acc_q <= '0;
		else if (v_s3)
			acc_q <= acc_q + NW'(sq_s3);
	end

	assign zf   = level ? Z_99_Q16 : Z_95_Q16;
	assign prod = zf * sqrt_root + 50'h8000;

	always_ff @(posedge clk) begin
		if (cmd.mean_ld)
			mean_q <= neg ? -div_quo[31:0] : div_quo[31:0];
		if (cmd.var_ld)
			var_q <= (div_quo[NW-1:64] != '0) ? '1 : div_quo[63:0];
		if (cmd.var_n_ld)
			var_n_q <= div_quo[63:0];
		if (cmd.half_ld)
			half_q <= prod[49:16];
	end

	assign m36       = {{4{mean_q[31]}}, mean_q};
	assign lo36      = m36 - {2'b00, half_q};
	assign hi36      = m36 + {2'b00, half_q};
	assign count_ext = {11'd0, count_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (cmd.out_ld)
			out_valid_q <= 1'b1;
		else if (out_ready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (cmd.out_ld)
			out_data_q <= {4'd0, drop_q, count_ext[10:0], sat32(hi36), sat32(lo36),
				var_q, mean_q};
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	assign status.last_xfer = in_xfer && in_last;
	assign status.div_done  = div_done;
	assign status.pass_done = idx_q == count_q && !v_s1 && !v_s2 && !v_s3;
	assign status.sqrt_done = sqrt_done;
	assign status.out_free  = !out_valid_q || out_ready;
endmodule
`default_nettype wire

// ===== hdl/smvc_ctrl.sv =====
// controller sequencing load, mean, deviation pass, divisions, root and result
`default_nettype none
module smvc_ctrl (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire smvc_pkg::dp_status_t status,
	output smvc_pkg::dp_cmd_t         cmd,
	output logic                      accepting
);
	import smvc_pkg::*;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_MEAN_GO,
		ST_MEAN_WAIT,
		ST_PASS_GO,
		ST_PASS,
		ST_VAR_GO,
		ST_VAR_WAIT,
		ST_VN_GO,
		ST_VN_WAIT,
		ST_SQRT_GO,
		ST_SQRT_WAIT,
		ST_HALF,
		ST_OUT
	} state_t;

	state_t state_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			case (state_q)
				ST_IDLE:      if (status.last_xfer) state_q <= ST_MEAN_GO;
				ST_MEAN_GO:   state_q <= ST_MEAN_WAIT;
				ST_MEAN_WAIT: if (status.div_done) state_q <= ST_PASS_GO;
				ST_PASS_GO:   state_q <= ST_PASS;
				ST_PASS:      if (status.pass_done) state_q <= ST_VAR_GO;
				ST_VAR_GO:    state_q <= ST_VAR_WAIT;
				ST_VAR_WAIT:  if (status.div_done) state_q <= ST_VN_GO;
				ST_VN_GO:     state_q <= ST_VN_WAIT;
				ST_VN_WAIT:   if (status.div_done) state_q <= ST_SQRT_GO;
				ST_SQRT_GO:   state_q <= ST_SQRT_WAIT;
				ST_SQRT_WAIT: if (status.sqrt_done) state_q <= ST_HALF;
				ST_HALF:      state_q <= ST_OUT;
				ST_OUT:       if (status.out_free) state_q <= ST_IDLE;
				default:      state_q <= ST_IDLE;
			endcase
		end
	end

	always_comb begin
		cmd            = '0;
		cmd.div_sel    = DIV_MEAN;
		case (state_q)
			ST_MEAN_GO:   cmd.div_start = 1'b1;
			ST_MEAN_WAIT: cmd.mean_ld = status.div_done;
			ST_PASS_GO:   cmd.pass_start = 1'b1;
			ST_PASS:      cmd.pass_run = 1'b1;
			ST_VAR_GO: begin
				cmd.div_sel   = DIV_VAR;
				cmd.div_start = 1'b1;
			end
			ST_VAR_WAIT:  cmd.var_ld = status.div_done;
			ST_VN_GO: begin
				cmd.div_sel   = DIV_VAR_N;
				cmd.div_start = 1'b1;
			end
			ST_VN_WAIT:   cmd.var_n_ld = status.div_done;
			ST_SQRT_GO:   cmd.sqrt_start = 1'b1;
			ST_HALF:      cmd.half_ld = 1'b1;
			ST_OUT:       cmd.out_ld = status.out_free;
			default:      cmd.pass_run = 1'b0;
		endcase
	end

	assign accepting = state_q == ST_IDLE;
endmodule
`default_nettype wire

// ===== hdl/sample_mean_variance_confidence_core.sv =====
// top level: stream ports, level register and the controller with its datapath
`default_nettype none
// Samples (signed Q16.16) are taken one per cycle into a MAX_SAMPLES-entry store
// while a running sum is kept; once the store is full further samples are dropped
// and flagged. The transfer marked tlast starts the computation, during which no
// sample is taken: a mean division, one pass over the n stored samples, two more
// divisions of the shared bit-serial divider (three in all) and a square root. The
// result waits in an output register; the next set may be loaded while it is
// still held, but its own result waits until this one is taken. The level
// register at address 0 selects z = 1.96 (0) or 2.576 (1).
module sample_mean_variance_confidence_core #(
	parameter int MAX_SAMPLES = 1024
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         psel,
	input  wire logic         penable,
	input  wire logic         pwrite,
	input  wire logic [2:0]   paddr,
	input  wire logic [31:0]  pwdata,
	output logic      [31:0]  prdata,
	output logic              pready,
	input  wire logic         s_tvalid,
	output logic              s_tready,
	input  wire logic [31:0]  s_tdata,   // sample_value
	input  wire logic         s_tlast,   // last_sample
	output logic              m_tvalid,
	input  wire logic         m_tready,
	// mean_value, variance_value, lower_bound, upper_bound, sample_count, overflow_flag
	output logic      [smvc_pkg::OUT_DATA_W-1:0] m_tdata
);
	import smvc_pkg::*;

	dp_cmd_t    cmd;
	dp_status_t status;
	logic       level_q;
	logic       accepting;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			level_q <= 1'b0;
		else if (psel && penable && pwrite && !paddr[2])
			level_q <= pwdata[0];
	end

	assign pready   = 1'b1;
	assign prdata   = paddr[2] ? 32'd0 : {31'd0, level_q};
	assign s_tready = accepting;

	smvc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.status    (status),
		.cmd       (cmd),
		.accepting (accepting)
	);

	smvc_datapath #(.MAX_SAMPLES(MAX_SAMPLES)) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.status    (status),
		.level     (level_q),
		.in_xfer   (s_tvalid && accepting),
		.in_sample (s_tdata),
		.in_last   (s_tlast),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_data  (m_tdata)
	);
endmodule
`default_nettype wire

// ===== dv/tb_top.sv =====
// testbench for the sample mean, variance and confidence core: directed and random sets
`default_nettype none
module tb_top;
	import smvc_pkg::*;

	localparam int CAP = 1024;
	localparam logic [2:0] LEVEL_ADDR = 3'd0;

	typedef struct packed {
		logic        ovf;
		logic [10:0] cnt;
		logic [31:0] upper;
		logic [31:0] lower;
		logic [63:0] var_q;
		logic [31:0] mean;
	} stats_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
	logic [2:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic pready;
	logic s_tvalid = 1'b0, s_tlast = 1'b0, s_tready;
	logic [31:0] s_tdata = '0;
	logic m_tvalid, m_tready = 1'b0;
	logic [OUT_DATA_W-1:0] m_tdata;

	// predictor state
	logic signed [31:0] set_store [CAP];
	int unsigned set_count;
	logic signed [41:0] set_sum;
	logic set_dropped;
	logic level_sel;

	stats_t expected_stats [$];
	int errors = 0;
	int rx_idle = 0;
	bit idle_on = 1'b1;
	bit hold_off = 1'b0;

	always #10 clk = ~clk;

	sample_mean_variance_confidence_core dut (.*);

	function automatic logic [63:0] isqrt(input logic [63:0] x);
		logic [63:0] rem, root, b;
		rem = x; root = 0; b = 64'd1 << 62;
		while (b > rem) b >>= 2;
		while (b != 0) begin
			if (rem >= root + b) begin
				rem -= root + b;
				root = (root >> 1) + b;
			end else begin
				root >>= 1;
			end
			b >>= 2;
		end
		return root;
	endfunction

	function automatic logic signed [31:0] clamp32(input logic signed [63:0] v);
		if (v > 64'sd2147483647) return 32'sh7fffffff;
		if (v < -64'sd2147483648) return 32'sh80000000;
		return v[31:0];
	endfunction

	// updates the set and returns 1 with the statistics when the set closes
	function automatic bit predict_stats(input logic [31:0] x, input logic last,
			output stats_t r);
		logic signed [63:0] mean, d, half;
		logic [127:0] acc, q;
		logic [63:0] v, s;
		logic [17:0] z;
		int unsigned n;
		longint sum64, nn;
		if (set_count < CAP) begin
			set_store[set_count] = x;
			set_count++;
			set_sum += {{10{x[31]}}, x};
		end else begin
			set_dropped = 1'b1;
		end
		if (!last) return 0;
		n = set_count;
		sum64 = set_sum;
		nn = n;
		if (sum64 >= 0) mean = sum64 / nn;
		else mean = -((-sum64 + nn - 1) / nn);
		acc = 0;
		for (int i = 0; i < n; i++) begin
			d = set_store[i] - mean;
			if (d < 0) d = -d;
			acc += d * d;
		end
		q = acc / n;
		v = (q[127:64] != 0) ? '1 : q[63:0];
		s = isqrt(v / n);
		z = level_sel ? Z_99_Q16 : Z_95_Q16;
		half = (z * s + 64'h8000) >> 16;
		r.mean = mean[31:0];
		r.var_q = v;
		r.lower = clamp32(mean - half);
		r.upper = clamp32(mean + half);
		r.cnt = n[10:0];
		r.ovf = set_dropped;
		set_count = 0; set_sum = 0; set_dropped = 1'b0;
		return 1;
	endfunction

	// valid stays up between back-to-back transfers and drops only for idling
	task automatic send_sample(input logic [31:0] x, input logic last);
		stats_t r;
		if (idle_on && $urandom_range(0, 5) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 3)) @(posedge clk);
		end
		s_tvalid <= 1'b1; s_tdata <= x; s_tlast <= last;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		if (predict_stats(x, last, r)) expected_stats.push_back(r);
	endtask

	task automatic drain;
		s_tvalid <= 1'b0;
		while (expected_stats.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	task automatic write_level(input logic v);
		psel <= 1'b1; pwrite <= 1'b1; paddr <= LEVEL_ADDR; pwdata <= {31'd0, v};
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
		level_sel = v;
	endtask

	function automatic logic [31:0] rand_sample(input int mode);
		case (mode)
			0: return $urandom();
			1: return $urandom_range(0, 65535 * 8) - 65535 * 4;
			default: return $urandom_range(0, 1) ? 32'h7fffffff : 32'h80000000;
		endcase
	endfunction

	// result checker with random receiver stalls
	always @(posedge clk) begin
		stats_t got, exp_r;
		if (m_tvalid && m_tready) begin
			got = m_tdata[$bits(stats_t)-1:0];
			if (expected_stats.size() == 0) begin
				errors++;
				if (errors <= 10) $display("unexpected transfer %h", got);
			end else begin
				exp_r = expected_stats.pop_front();
				if (got !== exp_r) begin
					errors++;
					if (errors <= 10)
						$display("mismatch exp mean %h var %h lo %h hi %h n %0d ovf %b",
							exp_r.mean, exp_r.var_q, exp_r.lower, exp_r.upper,
							exp_r.cnt, exp_r.ovf, "\n         got mean %h var %h lo %h hi %h n %0d ovf %b",
							got.mean, got.var_q, got.lower, got.upper, got.cnt, got.ovf);
				end
			end
		end
		if (rx_idle > 0) begin
			rx_idle--;
			m_tready <= 1'b0;
		end else if (idle_on && $urandom_range(0, 4) == 0) begin
			rx_idle = $urandom_range(0, 2);
			m_tready <= 1'b0;
		end else begin
			m_tready <= !hold_off;
		end
	end

	task automatic test_directed;
		send_sample(32'h7fffffff, 1'b1);
		send_sample(32'h80000000, 1'b1);
		send_sample(32'h7fffffff, 1'b0);
		send_sample(32'h80000000, 1'b1);
		send_sample(32'h00010000, 1'b0);
		send_sample(32'hffff0000, 1'b0);
		send_sample(32'h00000003, 1'b1);
		send_sample(32'hffffffff, 1'b0);
		send_sample(32'hfffffffe, 1'b1);
		send_sample(32'h0, 1'b0);
		send_sample(32'h0, 1'b1);
		for (int i = 0; i < 6; i++) send_sample(i[0] ? 32'h7fffffff : 32'h80000000, i == 5);
		drain();
		write_level(1'b1);
		send_sample(32'h80000000, 1'b0);
		send_sample(32'h7fffffff, 1'b0);
		send_sample(32'h12345678, 1'b1);
		drain();
	endtask

	// full store plus dropped samples, including a dropped last sample
	task automatic test_overflow;
		for (int i = 0; i < CAP + 3; i++) send_sample(rand_sample(i % 3), i == CAP + 2);
		drain();
		write_level(1'b0);
	endtask

	task automatic test_backpressure;
		hold_off = 1'b1;
		fork
			begin
				for (int k = 0; k < 6; k++)
					for (int i = 0; i < 4; i++) send_sample(rand_sample(1), i == 3);
				send_sample(rand_sample(0), 1'b1);
				send_sample(rand_sample(0), 1'b1);
			end
			begin
				repeat (3000) @(posedge clk);
				hold_off = 1'b0;
			end
		join
		drain();
	endtask

	task automatic test_random;
		int len, mode;
		for (int k = 0; k < 8; k++) begin
			if (k == 3 || k == 6) begin
				drain();
				write_level(k == 3);
			end
			if (k == 6) idle_on = 1'b0;
			len = $urandom_range(1, 20);
			mode = $urandom_range(0, 2);
			for (int i = 0; i < len; i++)
				send_sample(rand_sample($urandom_range(0, 4) == 0 ? 0 : mode), i == len - 1);
		end
	endtask

	initial begin
		set_count = 0; set_sum = 0; set_dropped = 1'b0; level_sel = 1'b0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_overflow();
		test_backpressure();
		test_random();
		drain();
		if (errors == 0) $display("DONE: 0 errors");
		else $display("DONE: errors detected");
		$finish;
	end

	initial begin
		#20000000;
		$display("DONE: errors detected");
		$finish;
	end
endmodule
`default_nettype wire

// ===== filelist.f =====
hdl/smvc_pkg.sv
hdl/smvc_div.sv
hdl/smvc_sqrt.sv
hdl/smvc_datapath.sv
hdl/smvc_ctrl.sv
hdl/sample_mean_variance_confidence_core.sv
dv/tb_top.sv
